@@ rtl/ntri_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and status structs of the negative triangle search
package ntri_pkg;

    localparam int NUM_CURRENCIES_DEF = 8;
    localparam int IDX_W  = 3;
    localparam int SLOT_W = 2 * IDX_W;
    localparam int COST_W = 32;
    localparam int SUM_W  = 34;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // walker to evaluator: stage 1 pair info and finish request
    typedef struct packed {
        logic             valid;
        logic             head;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic             p23;
        logic             p1;
        logic [IDX_W-1:0] start;
        logic             fin_req;
    } walk_stat_t;

    // evaluator to walker: pipeline advance and finish done
    typedef struct packed {
        logic advance;
        logic fin_done;
    } eval_stat_t;

endpackage

@@ rtl/ntri_if.sv @@
`timescale 1ns / 1ps
// command and result channel interfaces
interface ntri_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [ntri_pkg::IDX_W-1:0]  from_index;
    logic [ntri_pkg::IDX_W-1:0]  to_index;
    logic signed [ntri_pkg::COST_W-1:0] log_cost;
    logic                        rate_present;

    modport source (output valid, operation, from_index, to_index, log_cost, rate_present,
                    input ready);
    modport sink (input valid, operation, from_index, to_index, log_cost, rate_present,
                  output ready);
endinterface

interface ntri_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [ntri_pkg::IDX_W-1:0]  first_index;
    logic [ntri_pkg::IDX_W-1:0]  second_index;
    logic [ntri_pkg::IDX_W-1:0]  third_index;
    logic signed [ntri_pkg::SUM_W-1:0] cycle_cost;
    logic                        last;

    modport source (output valid, found, first_index, second_index, third_index,
                    cycle_cost, last, input ready);
    modport sink (input valid, found, first_index, second_index, third_index,
                  cycle_cost, last, output ready);
endinterface

@@ rtl/negative_triangle_search_top.sv @@
`timescale 1ns / 1ps
// top level of the negative triangle search over a stored edge cost matrix
//
//  channel  dir  handshake     word
//  cmd      in   valid/ready   operation, from_index, to_index, log_cost, rate_present
//  result   out  valid/ready   found, first/second/third_index, cycle_cost, last
//
// a load word leaves the command side ready and gives no result word
// a search walks (N-1)*(N-1) ram read slots, one per cycle while the evaluator does not stall it:
// per second currency one slot fetches the start edge, then one slot per third currency
// reads the two remaining edges on the two ram read ports; the walk then drains and
// the final word is registered, and the command side stays closed until then
// reset clears the present bits, state and valid flags; the cost ram has no reset
// a stalled result word lets the walk run on until two more hits wait behind it,
// then the whole walk pipeline freezes until the word is taken
module negative_triangle_search_top #(
    parameter int NUM_CURRENCIES = ntri_pkg::NUM_CURRENCIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ntri_in_if.sink     cmd,
    ntri_out_if.source  result
);
    import ntri_pkg::*;

    // ram only spans the rows of currencies in use
    localparam int SLOT_DEPTH = NUM_CURRENCIES << IDX_W;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);

    walk_stat_t         ws;
    eval_stat_t         ev;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [COST_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr_a;
    logic [SLOT_W-1:0]  ram_raddr_b;
    logic [COST_W-1:0]  rd_a;
    logic [COST_W-1:0]  rd_b;

    // walker: intake, present bits, pair order, ram addresses
    ntri_walker #(
        .NUM_CURRENCIES (NUM_CURRENCIES)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .ev          (ev),
        .ws          (ws),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b)
    );

    // edge cost store, slot = {from, to}
    ntri_ram #(
        .WIDTH (COST_W),
        .DEPTH (SLOT_DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr[SLOT_AW-1:0]),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a[SLOT_AW-1:0]),
        .raddr_b (ram_raddr_b[SLOT_AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // evaluator: sum, sign test, hold one hit back so the last one can be marked
    ntri_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .ws     (ws),
        .rd_a   (rd_a),
        .rd_b   (rd_b),
        .ev     (ev),
        .result (result)
    );
endmodule

@@ rtl/ntri_ram.sv @@
`timescale 1ns / 1ps
// generic ram: one write port, two registered read ports
module ntri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

@@ rtl/ntri_walker.sv @@
`timescale 1ns / 1ps
// command intake, present bits and the (j, k) pair walk with ram addressing
module ntri_walker #(
    parameter int NUM_CURRENCIES = ntri_pkg::NUM_CURRENCIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ntri_in_if.sink                      cmd,
    input  ntri_pkg::eval_stat_t         ev,
    output ntri_pkg::walk_stat_t         ws,
    output logic                         ram_we,
    output logic [ntri_pkg::SLOT_W-1:0]  ram_waddr,
    output logic [ntri_pkg::COST_W-1:0]  ram_wdata,
    output logic                         ram_re,
    output logic [ntri_pkg::SLOT_W-1:0]  ram_raddr_a,
    output logic [ntri_pkg::SLOT_W-1:0]  ram_raddr_b
);
    import ntri_pkg::*;

    localparam int SLOT_DEPTH = NUM_CURRENCIES << IDX_W;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam logic [IDX_W:0] N_LIM = (IDX_W + 1)'(NUM_CURRENCIES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HEAD  = 2'd1;
    localparam logic [1:0] ST_PAIR  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // smallest index at or above c that is neither a nor b
    function automatic logic [IDX_W:0] next_free(input logic [IDX_W:0] c,
                                                 input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] r;
        r = c;
        if (r == {1'b0, a} || r == {1'b0, b})
        begin
            r = r + 1'b1;
        end
        if (r == {1'b0, a} || r == {1'b0, b})
        begin
            r = r + 1'b1;
        end
        return r;
    endfunction

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       start_reg;
    logic [IDX_W-1:0]       j_reg;
    logic [IDX_W-1:0]       k_reg;
    logic                   p1_reg;
    logic [SLOT_DEPTH-1:0]  pres_reg;
    logic                   s1_valid_reg;
    logic                   s1_head_reg;
    logic [IDX_W-1:0]       s1_j_reg;
    logic [IDX_W-1:0]       s1_k_reg;
    logic                   s1_p23_reg;

    logic                   accept;
    logic                   load_ok;
    logic [SLOT_W-1:0]      slot_in;
    logic [SLOT_W-1:0]      slot_ij;
    logic [SLOT_W-1:0]      slot_jk;
    logic [SLOT_W-1:0]      slot_ki;
    logic [IDX_W:0]         nk;
    logic [IDX_W:0]         nj;
    logic [IDX_W:0]         fj;
    logic [IDX_W:0]         fk;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign load_ok   = ({1'b0, cmd.from_index} < N_LIM) && ({1'b0, cmd.to_index} < N_LIM)
                       && (cmd.from_index != cmd.to_index);
    assign slot_in   = {cmd.from_index, cmd.to_index};
    assign slot_ij   = {start_reg, j_reg};
    assign slot_jk   = {j_reg, k_reg};
    assign slot_ki   = {k_reg, start_reg};

    assign nk = next_free({1'b0, k_reg} + 1'b1, start_reg, j_reg);
    assign nj = next_free({1'b0, j_reg} + 1'b1, start_reg, start_reg);
    assign fj = next_free('0, cmd.from_index, cmd.from_index);
    assign fk = next_free('0, start_reg, j_reg);

    assign ram_we      = accept && (cmd.operation == OP_LOAD) && load_ok && cmd.rate_present;
    assign ram_waddr   = slot_in;
    assign ram_wdata   = cmd.log_cost;
    assign ram_re      = ev.advance && (state_reg == ST_HEAD || state_reg == ST_PAIR);
    assign ram_raddr_a = (state_reg == ST_HEAD) ? slot_ij : slot_jk;
    assign ram_raddr_b = slot_ki;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.operation == OP_SEARCH)
                begin
                    state_next = ({1'b0, cmd.from_index} < N_LIM) ? ST_HEAD : ST_DRAIN;
                end
            end
            ST_HEAD:
            begin
                if (ev.advance)
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                if (ev.advance && nk >= N_LIM)
                begin
                    state_next = (nj < N_LIM) ? ST_HEAD : ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (ev.fin_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pres_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && cmd.operation == OP_LOAD && load_ok)
            begin
                pres_reg[slot_in[SLOT_AW-1:0]] <= cmd.rate_present;
            end
            if (ev.advance)
            begin
                s1_valid_reg <= (state_reg == ST_HEAD) || (state_reg == ST_PAIR);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.operation == OP_SEARCH)
        begin
            start_reg <= cmd.from_index;
            j_reg     <= fj[IDX_W-1:0];
        end
        if (ev.advance && state_reg == ST_HEAD)
        begin
            p1_reg      <= pres_reg[slot_ij[SLOT_AW-1:0]];
            k_reg       <= fk[IDX_W-1:0];
            s1_head_reg <= 1'b1;
        end
        if (ev.advance && state_reg == ST_PAIR)
        begin
            s1_head_reg <= 1'b0;
            s1_j_reg    <= j_reg;
            s1_k_reg    <= k_reg;
            s1_p23_reg  <= pres_reg[slot_jk[SLOT_AW-1:0]] && pres_reg[slot_ki[SLOT_AW-1:0]];
            if (nk < N_LIM)
            begin
                k_reg <= nk[IDX_W-1:0];
            end
            else
            begin
                j_reg <= nj[IDX_W-1:0];
            end
        end
    end

    assign ws.valid   = s1_valid_reg;
    assign ws.head    = s1_head_reg;
    assign ws.j       = s1_j_reg;
    assign ws.k       = s1_k_reg;
    assign ws.p23     = s1_p23_reg;
    assign ws.p1      = p1_reg;
    assign ws.start   = start_reg;
    assign ws.fin_req = (state_reg == ST_DRAIN);
endmodule

@@ rtl/ntri_eval.sv @@
`timescale 1ns / 1ps
// cost sum, sign test, one-deep hold for last marking and result register
module ntri_eval (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ntri_pkg::walk_stat_t         ws,
    input  logic [ntri_pkg::COST_W-1:0]  rd_a,
    input  logic [ntri_pkg::COST_W-1:0]  rd_b,
    output ntri_pkg::eval_stat_t         ev,
    ntri_out_if.source                   result
);
    import ntri_pkg::*;

    logic [COST_W-1:0]       c1_reg;
    logic                    s2_valid_reg;
    logic [IDX_W-1:0]        s2_j_reg;
    logic [IDX_W-1:0]        s2_k_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic                    pend_valid_reg;
    logic [IDX_W-1:0]        pend_j_reg;
    logic [IDX_W-1:0]        pend_k_reg;
    logic signed [SUM_W-1:0] pend_sum_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg;
    logic [IDX_W-1:0]        out_first_reg;
    logic [IDX_W-1:0]        out_second_reg;
    logic [IDX_W-1:0]        out_third_reg;
    logic signed [SUM_W-1:0] out_cost_reg;
    logic                    out_last_reg;

    logic signed [SUM_W-1:0] sum;
    logic                    hit;
    logic                    advance;
    logic                    out_free;
    logic                    fin_done;
    logic                    push_pend;

    assign sum = $signed({{(SUM_W - COST_W){c1_reg[COST_W-1]}}, c1_reg})
               + $signed({{(SUM_W - COST_W){rd_a[COST_W-1]}}, rd_a})
               + $signed({{(SUM_W - COST_W){rd_b[COST_W-1]}}, rd_b});
    assign hit = ws.valid && !ws.head && ws.p1 && ws.p23 && sum[SUM_W-1];

    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = !(s2_valid_reg && pend_valid_reg && !out_free);
    assign push_pend = advance && s2_valid_reg && pend_valid_reg;
    assign fin_done  = ws.fin_req && !ws.valid && !s2_valid_reg && out_free;

    assign ev.advance  = advance;
    assign ev.fin_done = fin_done;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_pend || fin_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                s2_valid_reg <= hit;
            end
            if (advance && s2_valid_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (fin_done)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ws.valid && ws.head)
        begin
            c1_reg <= rd_a;
        end
        if (advance)
        begin
            s2_j_reg   <= ws.j;
            s2_k_reg   <= ws.k;
            s2_sum_reg <= sum;
        end
        if (advance && s2_valid_reg)
        begin
            pend_j_reg   <= s2_j_reg;
            pend_k_reg   <= s2_k_reg;
            pend_sum_reg <= s2_sum_reg;
        end
        if (push_pend)
        begin
            out_found_reg  <= 1'b1;
            out_first_reg  <= ws.start;
            out_second_reg <= pend_j_reg;
            out_third_reg  <= pend_k_reg;
            out_cost_reg   <= pend_sum_reg;
            out_last_reg   <= 1'b0;
        end
        else if (fin_done)
        begin
            out_found_reg  <= pend_valid_reg;
            out_first_reg  <= ws.start;
            out_second_reg <= pend_valid_reg ? pend_j_reg : '0;
            out_third_reg  <= pend_valid_reg ? pend_k_reg : '0;
            out_cost_reg   <= pend_valid_reg ? pend_sum_reg : '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = out_found_reg;
    assign result.first_index  = out_first_reg;
    assign result.second_index = out_second_reg;
    assign result.third_index  = out_third_reg;
    assign result.cycle_cost   = out_cost_reg;
    assign result.last         = out_last_reg;
endmodule

@@ rtl/ntri_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the negative triangle search, bound to the top level
module ntri_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         cmd_operation,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_found,
    input logic [ntri_pkg::IDX_W-1:0]   res_first,
    input logic [ntri_pkg::IDX_W-1:0]   res_second,
    input logic [ntri_pkg::IDX_W-1:0]   res_third,
    input logic [ntri_pkg::SUM_W-1:0]   res_cost,
    input logic                         res_last
);
    import ntri_pkg::*;

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_cost) && $stable(res_last))
        else $error("result word changed under stall");

    // a search closes the command side
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_operation == OP_SEARCH |=> !cmd_ready)
        else $error("command accepted during search");

    // a load leaves the command side ready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_operation == OP_LOAD |=> cmd_ready)
        else $error("load did not return to idle");

    // empty search word is the single final word with zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_last && res_second == '0 && res_third == '0
                                    && res_cost == '0)
        else $error("malformed not-found word");

    // reported triangle is negative with distinct currencies
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found |-> res_cost[SUM_W-1] && res_first != res_second
                                   && res_second != res_third && res_third != res_first)
        else $error("bad triangle reported");
endmodule

bind negative_triangle_search_top ntri_checker u_ntri_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_operation (cmd.operation),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_found     (result.found),
    .res_first     (result.first_index),
    .res_second    (result.second_index),
    .res_third     (result.third_index),
    .res_cost      (result.cycle_cost),
    .res_last      (result.last)
);

@@ tb/sv/tb_negative_triangle_search_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the negative triangle search top level
module tb_negative_triangle_search_top;

    import ntri_pkg::*;

    localparam int NCUR         = NUM_CURRENCIES_DEF;
    localparam int GAP_MAX      = 18;
    // every item giving 42 words, each behind the longest receiver stall, plus the walk
    localparam int LIMIT_CYCLES = 1000000;
    // margin for the walk of one search plus drain
    localparam int SETTLE_CYCLES = 80;
    localparam logic signed [COST_W-1:0] Q_ONE  = 32'sh0100_0000;
    localparam logic signed [COST_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COST_W-1:0] Q_MIN  = 32'sh8000_0000;

    // one expected result word
    typedef struct packed {
        logic                    found;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        second_index;
        logic [IDX_W-1:0]        third_index;
        logic signed [SUM_W-1:0] cycle_cost;
        logic                    last;
    } triangle_word_t;

    logic clk;
    logic rst_n;

    ntri_in_if  cmd ();
    ntri_out_if result ();

    negative_triangle_search_top #(
        .NUM_CURRENCIES (NCUR)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .result (result)
    );

    // own copy of the edge matrix, index from*8+to
    logic signed [COST_W-1:0] edge_cost [64];
    logic                     edge_live [64];

    // triangles still owed by the block, oldest first
    triangle_word_t triangle_q [$];

    int  mismatch_count;
    int  cycle_count;
    int  hold_request;
    logic hold_active;
    bit  send_idle;
    bit  recv_idle;

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle draw for one word; zero is common so back-to-back traffic shows up too
    function automatic int pick_gap(bit enabled);
        if (!enabled)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // mostly small Q8.24 costs so that negative triangles are frequent,
    // with full random words and the extremes mixed in
    function automatic logic signed [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom();
            2, 3, 4: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0300_0000;
            5:       return Q_MAX;
            6:       return Q_MIN;
            default: return $signed($urandom_range(0, 255)) - 32'sh0000_0080;
        endcase
    endfunction

    function automatic logic signed [SUM_W-1:0] widen(logic signed [COST_W-1:0] c);
        return {{(SUM_W - COST_W){c[COST_W-1]}}, c};
    endfunction

    // append one expected word at the tail
    function automatic void owe_word(triangle_word_t w);
        triangle_q = {triangle_q, w};
    endfunction

    // load: diagonal and out-of-range edges are dropped, a clear keeps the stored cost
    function automatic void apply_load(logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
                                       logic signed [COST_W-1:0] cost, logic present);
        int slot;
        slot = src * 8 + dst;
        if (src == dst || src >= NCUR || dst >= NCUR)
            return;
        if (present)
        begin
            edge_cost[slot] = cost;
            edge_live[slot] = 1'b1;
        end
        else
        begin
            edge_live[slot] = 1'b0;
        end
    endfunction

    // search: walk j then k, queue every triangle whose sum is strictly negative
    function automatic void predict_triangles(logic [IDX_W-1:0] start);
        int n;
        int s1;
        int s2;
        int s3;
        logic signed [SUM_W-1:0] sum;
        triangle_word_t w;
        n = 0;
        if (start < NCUR)
        begin
            for (int j = 0; j < NCUR; j++)
            begin
                for (int k = 0; k < NCUR; k++)
                begin
                    if (j == start || k == start || k == j)
                        continue;
                    s1 = start * 8 + j;
                    s2 = j * 8 + k;
                    s3 = k * 8 + start;
                    if (!(edge_live[s1] && edge_live[s2] && edge_live[s3]))
                        continue;
                    sum = widen(edge_cost[s1]) + widen(edge_cost[s2]) + widen(edge_cost[s3]);
                    if (sum < 0)
                    begin
                        w.found        = 1'b1;
                        w.first_index  = start;
                        w.second_index = IDX_W'(j);
                        w.third_index  = IDX_W'(k);
                        w.cycle_cost   = sum;
                        w.last         = 1'b0;
                        owe_word(w);
                        n++;
                    end
                end
            end
        end
        if (n == 0)
        begin
            // nothing found: a single marker word
            w.found        = 1'b0;
            w.first_index  = start;
            w.second_index = '0;
            w.third_index  = '0;
            w.cycle_cost   = '0;
            w.last         = 1'b1;
            owe_word(w);
        end
        else
        begin
            triangle_q[triangle_q.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // compare one taken result word against the oldest expected triangle
    task automatic check_triangle(triangle_word_t got);
        triangle_word_t exp;
        if (triangle_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word found=%0b %0d->%0d->%0d cost=%0d",
                got.found, got.first_index, got.second_index, got.third_index,
                got.cycle_cost));
            return;
        end
        exp = triangle_q.pop_front();
        if (got.found !== exp.found)
            report_mismatch($sformatf("found %0b, want %0b", got.found, exp.found));
        if (got.first_index !== exp.first_index)
            report_mismatch($sformatf("first_index %0d, want %0d",
                got.first_index, exp.first_index));
        if (got.second_index !== exp.second_index)
            report_mismatch($sformatf("second_index %0d, want %0d",
                got.second_index, exp.second_index));
        if (got.third_index !== exp.third_index)
            report_mismatch($sformatf("third_index %0d, want %0d",
                got.third_index, exp.third_index));
        if (got.cycle_cost !== exp.cycle_cost)
            report_mismatch($sformatf("cycle_cost %0d, want %0d",
                got.cycle_cost, exp.cycle_cost));
        if (got.last !== exp.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, exp.last));
    endtask

    // result side: random stall after each taken word, forced low during a hold-off
    initial
    begin : result_sink
        int rx_wait;
        triangle_word_t got;
        rx_wait = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result.valid && result.ready)
                begin
                    got.found        = result.found;
                    got.first_index  = result.first_index;
                    got.second_index = result.second_index;
                    got.third_index  = result.third_index;
                    got.cycle_cost   = result.cycle_cost;
                    got.last         = result.last;
                    check_triangle(got);
                    rx_wait = pick_gap(recv_idle);
                end
                else if (rx_wait > 0)
                begin
                    rx_wait--;
                end
                result.ready <= (rx_wait == 0) && !hold_active;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin : hold_off
        hold_active <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_active <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_active <= 1'b0;
                hold_request = 0;
            end
        end
    end

    // offer one command word after a random gap, predict once it is taken
    task automatic send_word(logic op, logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
                             logic signed [COST_W-1:0] cost, logic present);
        int gap;
        gap = pick_gap(send_idle);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.operation    <= op;
        cmd.from_index   <= src;
        cmd.to_index     <= dst;
        cmd.log_cost     <= cost;
        cmd.rate_present <= present;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (op == OP_LOAD)
            apply_load(src, dst, cost, present);
        else
            predict_triangles(src);
    endtask

    task automatic load_edge(logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
                             logic signed [COST_W-1:0] cost, logic present);
        send_word(OP_LOAD, src, dst, cost, present);
    endtask

    // search words carry junk in the load-only fields
    task automatic search_from(logic [IDX_W-1:0] start);
        send_word(OP_SEARCH, start, IDX_W'($urandom()), $urandom(), 1'($urandom()));
    endtask

    // stop offering and wait for every owed word, then let the walk settle
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (triangle_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // empty graph, diagonal, extreme costs, zero sum, clearing and re-enabling
    task automatic test_directed();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        // nothing loaded yet: one not-found word each
        search_from(0);
        search_from(7);
        // a diagonal edge must be ignored
        load_edge(0, 0, Q_MIN, 1'b1);
        // three most negative costs: deepest possible sum
        load_edge(0, 1, Q_MIN, 1'b1);
        load_edge(1, 2, Q_MIN, 1'b1);
        load_edge(2, 0, Q_MIN, 1'b1);
        search_from(0);
        search_from(2);
        // three largest costs: positive, not reported
        load_edge(3, 4, Q_MAX, 1'b1);
        load_edge(4, 5, Q_MAX, 1'b1);
        load_edge(5, 3, Q_MAX, 1'b1);
        search_from(3);
        // a triangle that sums to exactly zero is not negative
        load_edge(5, 6, Q_ONE, 1'b1);
        load_edge(6, 7, Q_ONE, 1'b1);
        load_edge(7, 5, -(2 * Q_ONE), 1'b1);
        search_from(5);
        // clearing one edge breaks the triangle; the junk cost must not stick
        load_edge(1, 2, Q_MAX, 1'b0);
        search_from(0);
        // set again with zero cost, the old stored value is replaced
        load_edge(1, 2, '0, 1'b1);
        search_from(1);
        wait_drained();
    endtask

    // random graphs in phases with different idle patterns
    task automatic test_random_graph();
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase != 1);
            recv_idle = (phase != 2);
            for (int n = 0; n < 20; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    src = IDX_W'($urandom_range(0, NCUR - 1));
                    dst = ($urandom_range(0, 9) == 0) ? src : IDX_W'($urandom_range(0, NCUR - 1));
                    load_edge(src, dst, pick_cost(), $urandom_range(0, 6) != 0);
                end
                else
                begin
                    search_from(IDX_W'($urandom_range(0, NCUR - 1)));
                end
            end
            wait_drained();
        end
    endtask

    // fully connected negative graph with no idling on either side
    task automatic test_streaming();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int s = 0; s < NCUR; s++)
            for (int d = 0; d < NCUR; d++)
                if (s != d)
                    load_edge(IDX_W'(s), IDX_W'(d),
                              -Q_ONE - $signed($urandom_range(0, 255)), 1'b1);
        for (int n = 0; n < 4; n++)
            search_from(IDX_W'($urandom_range(0, NCUR - 1)));
        wait_drained();
    endtask

    // receiver holds off while searches keep coming, the block has to stall its input
    task automatic test_backpressure();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        hold_request = 400;
        for (int n = 0; n < 6; n++)
            search_from(IDX_W'($urandom_range(0, NCUR - 1)));
        // sender pauses here until every owed word has been taken
        wait_drained();
    endtask

    initial
    begin
        mismatch_count   = 0;
        cycle_count      = 0;
        hold_request     = 0;
        send_idle        = 1'b1;
        recv_idle        = 1'b1;
        for (int i = 0; i < 64; i++)
        begin
            edge_cost[i] = '0;
            edge_live[i] = 1'b0;
        end
        rst_n            <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.operation    <= OP_LOAD;
        cmd.from_index   <= '0;
        cmd.to_index     <= '0;
        cmd.log_cost     <= '0;
        cmd.rate_present <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_graph();
        test_streaming();
        test_backpressure();

        wait_drained();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
